// ----- design/mono_sprite_blitter_top_macros.svh -----
// Assertion macros shared by the blitter checker.
`ifndef MONO_SPRITE_BLITTER_TOP_MACROS_SVH
`define MONO_SPRITE_BLITTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MSB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("blitter check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MSB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("blitter check failed");

`endif

// ----- design/msb_pkg.sv -----
`default_nettype none

package msb_pkg;

    localparam int SCREEN_W_DEF    = 84;
    localparam int SCREEN_H_DEF    = 48;
    localparam int SPRITE_BITS_DEF = 1024;
    localparam int READ_SPAN       = 42;
    localparam int WORD_BITS       = 16;
    localparam int COORD_W         = 10;

    typedef enum logic [2:0] {
        OP_LOAD       = 3'd0,
        OP_DRAW       = 3'd1,
        OP_OUTLINE    = 3'd2,
        OP_INV_RECT   = 3'd3,
        OP_INV_SCREEN = 3'd4,
        OP_READ       = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        MODE_SPRITE = 2'd0,
        MODE_RECT   = 2'd1,
        MODE_READ   = 2'd2
    } t_mode;

    typedef struct packed {
        logic start;
        logic spr_rd;
        logic spr_acc;
        logic row_rd;
        logic row_wr;
        logic nb_next;
        logic row_next;
        logic pass_switch;
        logic done;
        logic reject;
        logic read_out;
    } t_dp_cmd;

    typedef struct packed {
        logic  reject_in;
        logic  empty_in;
        logic  last_col;
        logic  last_row;
        logic  nb_last;
        logic  clear_pass;
        t_mode mode;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- design/msb_ctrl.sv -----
`default_nettype none

module msb_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire logic [2:0]            i_op,
    input  wire msb_pkg::t_dp_status   i_st,
    output msb_pkg::t_dp_cmd           o_cmd,
    output logic                       o_busy
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SPR_RD  = 5'b00010,
        S_SPR_ACC = 5'b00100,
        S_ROW_RD  = 5'b01000,
        S_ROW_WR  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Sequence commands to the datapath
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    o_cmd.start = 1'b1;
                    case (msb_pkg::t_op'(i_op))
                        msb_pkg::OP_LOAD: begin
                            o_cmd.done = 1'b1;
                        end
                        msb_pkg::OP_DRAW, msb_pkg::OP_OUTLINE: begin
                            if (i_st.reject_in) begin
                                o_cmd.done   = 1'b1;
                                o_cmd.reject = 1'b1;
                            end else if (i_st.empty_in) begin
                                o_cmd.done = 1'b1;
                            end else begin
                                n_state = S_SPR_RD;
                            end
                        end
                        msb_pkg::OP_INV_RECT: begin
                            if (i_st.empty_in) begin
                                o_cmd.done = 1'b1;
                            end else begin
                                n_state = S_ROW_RD;
                            end
                        end
                        msb_pkg::OP_INV_SCREEN: begin
                            n_state = S_ROW_RD;
                        end
                        msb_pkg::OP_READ: begin
                            if (i_st.reject_in) begin
                                o_cmd.done   = 1'b1;
                                o_cmd.reject = 1'b1;
                            end else begin
                                n_state = S_ROW_RD;
                            end
                        end
                        default: begin
                            o_cmd.done = 1'b1;
                        end
                    endcase
                end
            end
            S_SPR_RD: begin
                o_cmd.spr_rd = 1'b1;
                n_state      = S_SPR_ACC;
            end
            S_SPR_ACC: begin
                o_cmd.spr_acc = 1'b1;
                n_state       = i_st.last_col ? S_ROW_RD : S_SPR_RD;
            end
            S_ROW_RD: begin
                o_cmd.row_rd = 1'b1;
                n_state      = S_ROW_WR;
            end
            S_ROW_WR: begin
                o_cmd.row_wr = 1'b1;
                case (i_st.mode)
                    msb_pkg::MODE_READ: begin
                        o_cmd.done     = 1'b1;
                        o_cmd.read_out = 1'b1;
                        n_state        = S_IDLE;
                    end
                    msb_pkg::MODE_RECT: begin
                        if (i_st.last_row) begin
                            o_cmd.done = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            o_cmd.row_next = 1'b1;
                            n_state        = S_ROW_RD;
                        end
                    end
                    msb_pkg::MODE_SPRITE: begin
                        if (i_st.clear_pass && !i_st.nb_last) begin
                            o_cmd.nb_next = 1'b1;
                            n_state       = S_ROW_RD;
                        end else if (i_st.last_row) begin
                            if (i_st.clear_pass) begin
                                o_cmd.pass_switch = 1'b1;
                                n_state           = S_SPR_RD;
                            end else begin
                                o_cmd.done = 1'b1;
                                n_state    = S_IDLE;
                            end
                        end else begin
                            o_cmd.row_next = 1'b1;
                            n_state        = S_SPR_RD;
                        end
                    end
                    default: begin
                        o_cmd.done = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- design/msb_dp.sv -----
`default_nettype none

module msb_dp #(
    parameter int SCREEN_W    = msb_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H    = msb_pkg::SCREEN_H_DEF,
    parameter int SPRITE_BITS = msb_pkg::SPRITE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire msb_pkg::t_dp_cmd       i_cmd,
    input  wire logic [2:0]             i_op,
    input  wire logic signed [7:0]      i_pos_x,
    input  wire logic signed [7:0]      i_pos_y,
    input  wire logic [6:0]             i_width,
    input  wire logic [6:0]             i_height,
    input  wire logic signed [7:0]      i_end_x,
    input  wire logic signed [7:0]      i_end_y,
    input  wire logic [5:0]             i_sprite_addr,
    input  wire logic [15:0]            i_sprite_bits,
    input  wire logic [5:0]             i_read_row,
    input  wire logic                   i_read_half,
    output msb_pkg::t_dp_status         o_st,
    output logic                        o_done,
    output logic [msb_pkg::READ_SPAN-1:0] o_read_pixels,
    output logic                        o_status
);

    localparam int SPR_WORDS = SPRITE_BITS / msb_pkg::WORD_BITS;
    localparam int SAW       = $clog2(SPR_WORDS);
    localparam int IW        = $clog2(SPRITE_BITS);
    localparam int RW        = $clog2(SCREEN_H);
    localparam int XW        = $clog2(SCREEN_W);
    localparam int CW        = msb_pkg::COORD_W;
    localparam int SPAN      = msb_pkg::READ_SPAN;
    localparam logic signed [CW-1:0] W_LIM  = CW'(SCREEN_W);
    localparam logic signed [CW-1:0] H_LIM  = CW'(SCREEN_H);
    localparam logic signed [CW-1:0] H_LAST = CW'(SCREEN_H - 1);

    // Stores
    logic [msb_pkg::WORD_BITS-1:0] spr_mem [SPR_WORDS];
    logic [SCREEN_W-1:0]           frame_mem [SCREEN_H];
    logic [SCREEN_H-1:0]           r_row_valid;

    // Command registers
    msb_pkg::t_mode               r_mode;
    logic signed [CW-1:0]         r_px;
    logic signed [CW-1:0]         r_py;
    logic signed [CW-1:0]         r_fy;
    logic signed [CW-1:0]         r_ylast;
    logic [6:0]                   r_w;
    logic [6:0]                   r_h;
    logic [6:0]                   r_r;
    logic [6:0]                   r_c;
    logic [IW-1:0]                r_idx;
    logic [SCREEN_W-1:0]          r_mask;
    logic signed [1:0]            r_nb;
    logic                         r_clear;
    logic                         r_half;
    logic [msb_pkg::WORD_BITS-1:0] r_spr_q;
    logic [SCREEN_W-1:0]          r_frame_q;
    logic                         r_q_valid;
    logic                         r_done;
    logic [SPAN-1:0]              r_pixels;
    logic                         r_status;

    // Input decode
    logic signed [CW-1:0] px_in;
    logic signed [CW-1:0] py_in;
    logic signed [CW-1:0] ex_in;
    logic signed [CW-1:0] ey_in;
    logic signed [CW-1:0] rect_y0;
    logic signed [CW-1:0] rect_y1;
    logic [13:0]          area;
    logic                 oversize;
    logic                 bad_row;
    logic [SCREEN_W-1:0]  rect_mask;

    assign px_in    = CW'(i_pos_x);
    assign py_in    = CW'(i_pos_y);
    assign ex_in    = CW'(i_end_x);
    assign ey_in    = CW'(i_end_y);
    assign rect_y0  = (py_in < 0) ? '0 : py_in;
    assign rect_y1  = (ey_in > H_LAST) ? H_LAST : ey_in;
    assign area     = 14'(i_width) * 14'(i_height);
    assign oversize = 32'(area) > SPRITE_BITS;
    assign bad_row  = 32'(i_read_row) >= SCREEN_H;

    // Build the clipped column span of a rectangle
    always_comb begin
        logic signed [CW-1:0] kx;
        kx = '0;
        for (int k = 0; k < SCREEN_W; k++) begin
            kx           = CW'(k);
            rect_mask[k] = (kx >= px_in) && (kx <= ex_in);
        end
    end

    // Early status of the offered command
    always_comb begin
        o_st.reject_in = 1'b0;
        o_st.empty_in  = 1'b0;
        case (msb_pkg::t_op'(i_op))
            msb_pkg::OP_DRAW, msb_pkg::OP_OUTLINE: begin
                o_st.reject_in = oversize;
                o_st.empty_in  = (i_width == '0) || (i_height == '0);
            end
            msb_pkg::OP_INV_RECT: begin
                o_st.empty_in = rect_y0 > rect_y1;
            end
            msb_pkg::OP_READ: begin
                o_st.reject_in = bad_row;
            end
            default: begin
                o_st.reject_in = 1'b0;
            end
        endcase
    end

    // Running status
    assign o_st.last_col   = (r_c == r_w - 7'd1);
    assign o_st.last_row   = (r_mode == msb_pkg::MODE_SPRITE) ? (r_r == r_h - 7'd1)
                                                              : (r_fy == r_ylast);
    assign o_st.nb_last    = (r_nb == 2'sd1);
    assign o_st.clear_pass = r_clear;
    assign o_st.mode       = r_mode;

    // Current sprite pixel and target frame row
    logic signed [CW-1:0] pix_x;
    logic signed [CW-1:0] row_t;
    logic                 x_on;
    logic                 y_on;
    logic                 row_on;
    logic [RW-1:0]        row_addr;
    logic                 spr_bit;

    assign pix_x    = r_px + $signed(CW'(r_c));
    assign x_on     = (pix_x >= 0) && (pix_x < W_LIM);
    assign y_on     = (r_fy >= 0) && (r_fy < H_LIM);
    assign row_t    = r_fy + CW'(r_nb);
    assign row_on   = (row_t >= 0) && (row_t < H_LIM);
    assign row_addr = row_t[RW-1:0];
    assign spr_bit  = r_spr_q[r_idx[3:0]];

    // Row update: set, clear the dilated outline, or invert
    logic [SCREEN_W-1:0] row_q;
    logic [SCREEN_W-1:0] dilated;
    logic [SCREEN_W-1:0] row_wdata;
    logic                row_we;

    assign row_q   = r_q_valid ? r_frame_q : '0;
    assign dilated = r_mask | (r_mask << 1) | (r_mask >> 1);
    assign row_we  = i_cmd.row_wr && row_on && (r_mode != msb_pkg::MODE_READ);

    always_comb begin
        case (r_mode)
            msb_pkg::MODE_SPRITE: row_wdata = r_clear ? (row_q & ~dilated) : (row_q | r_mask);
            default:              row_wdata = row_q ^ r_mask;
        endcase
    end

    // Pick the requested half of the row
    logic [SCREEN_W+SPAN-1:0] row_ext;
    logic [SCREEN_W+SPAN-1:0] row_shift;

    assign row_ext   = {SPAN'(0), row_q};
    assign row_shift = row_ext >> (r_half ? 7'(SPAN) : 7'd0);

    // Write a sprite word, read one for the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && (msb_pkg::t_op'(i_op) == msb_pkg::OP_LOAD)
            && (32'(i_sprite_addr) < SPR_WORDS)) begin
            spr_mem[SAW'(i_sprite_addr)] <= i_sprite_bits;
        end
        if (i_cmd.spr_rd) begin
            r_spr_q <= spr_mem[r_idx[IW-1:4]];
        end
    end

    // Frame rows: registered read, write back
    always_ff @(posedge i_clk) begin
        if (row_we) begin
            frame_mem[row_addr] <= row_wdata;
        end
        if (i_cmd.row_rd && row_on) begin
            r_frame_q <= frame_mem[row_addr];
            r_q_valid <= r_row_valid[row_addr];
        end
    end

    // Track rows written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (row_we) begin
            r_row_valid[row_addr] <= 1'b1;
        end
    end

    // Latch the command and step the scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_nb    <= 2'sd0;
            r_clear <= 1'b0;
            r_r     <= '0;
            r_c     <= '0;
            r_idx   <= '0;
            r_half  <= i_read_half;
            case (msb_pkg::t_op'(i_op))
                msb_pkg::OP_DRAW, msb_pkg::OP_OUTLINE: begin
                    r_mode  <= msb_pkg::MODE_SPRITE;
                    r_clear <= (msb_pkg::t_op'(i_op) == msb_pkg::OP_OUTLINE);
                    r_nb    <= (msb_pkg::t_op'(i_op) == msb_pkg::OP_OUTLINE) ? -2'sd1 : 2'sd0;
                    r_px    <= px_in;
                    r_py    <= py_in;
                    r_fy    <= py_in;
                    r_w     <= i_width;
                    r_h     <= i_height;
                    r_mask  <= '0;
                end
                msb_pkg::OP_INV_RECT: begin
                    r_mode  <= msb_pkg::MODE_RECT;
                    r_fy    <= rect_y0;
                    r_ylast <= rect_y1;
                    r_mask  <= rect_mask;
                end
                msb_pkg::OP_INV_SCREEN: begin
                    r_mode  <= msb_pkg::MODE_RECT;
                    r_fy    <= '0;
                    r_ylast <= H_LAST;
                    r_mask  <= '1;
                end
                msb_pkg::OP_READ: begin
                    r_mode <= msb_pkg::MODE_READ;
                    r_fy   <= CW'(i_read_row);
                end
                default: begin
                    r_mode <= msb_pkg::MODE_READ;
                end
            endcase
        end else if (i_cmd.spr_acc) begin
            if (spr_bit && x_on && y_on) begin
                r_mask[pix_x[XW-1:0]] <= 1'b1;
            end
            r_c   <= r_c + 7'd1;
            r_idx <= r_idx + IW'(1);
        end else if (i_cmd.nb_next) begin
            r_nb <= r_nb + 2'sd1;
        end else if (i_cmd.row_next) begin
            r_fy <= r_fy + CW'(1);
            if (r_mode == msb_pkg::MODE_SPRITE) begin
                r_r    <= r_r + 7'd1;
                r_c    <= '0;
                r_mask <= '0;
                r_nb   <= r_clear ? -2'sd1 : 2'sd0;
            end
        end else if (i_cmd.pass_switch) begin
            r_clear <= 1'b0;
            r_r     <= '0;
            r_c     <= '0;
            r_idx   <= '0;
            r_mask  <= '0;
            r_fy    <= r_py;
            r_nb    <= 2'sd0;
        end
    end

    // Result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.done) begin
            r_status <= i_cmd.reject;
            r_pixels <= i_cmd.read_out ? row_shift[SPAN-1:0] : '0;
        end
    end

    assign o_done        = r_done;
    assign o_read_pixels = r_pixels;
    assign o_status      = r_status;

endmodule

`default_nettype wire

// ----- design/mono_sprite_blitter_top.sv -----
`default_nettype none

// Monochrome sprite blitter with an SCREEN_W x SCREEN_H one-bit framebuffer
// and a SPRITE_BITS sprite store loaded a 16-bit word at a time. A command is
// taken when start is high and busy is low; its single result beat shows on
// o_read_pixels/o_status for one cycle with o_done high and cannot be held
// off, so the receiver must take it then. Loads, rejected commands, empty
// draws, empty rectangle inversions and unused opcodes answer in the cycle
// after start. A read passes through a row read and a row write state before
// its beat. An outlined draw first clears the dilated outline, then draws the
// sprite; each sprite sample is fetched in a read state and taken in an
// accumulate state, and each frame row is updated by a read then a write of
// the row memory. The framebuffer reads as zero after reset through per-row
// valid bits, with no clearing pass.
module mono_sprite_blitter_top #(
    parameter int SCREEN_W    = msb_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H    = msb_pkg::SCREEN_H_DEF,
    parameter int SPRITE_BITS = msb_pkg::SPRITE_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [2:0]              i_op,
    input  wire logic signed [7:0]       i_pos_x,
    input  wire logic signed [7:0]       i_pos_y,
    input  wire logic [6:0]              i_width,
    input  wire logic [6:0]              i_height,
    input  wire logic signed [7:0]       i_end_x,
    input  wire logic signed [7:0]       i_end_y,
    input  wire logic [5:0]              i_sprite_addr,
    input  wire logic [15:0]             i_sprite_bits,
    input  wire logic [5:0]              i_read_row,
    input  wire logic                    i_read_half,
    output logic                         o_done,
    output logic [msb_pkg::READ_SPAN-1:0] o_read_pixels,
    output logic                         o_status
);

    msb_pkg::t_dp_cmd    cmd;
    msb_pkg::t_dp_status st;
    logic                accept;

    assign accept = start && !busy;

    msb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_op     (i_op),
        .i_st     (st),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    msb_dp #(
        .SCREEN_W    (SCREEN_W),
        .SCREEN_H    (SCREEN_H),
        .SPRITE_BITS (SPRITE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_op          (i_op),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_width       (i_width),
        .i_height      (i_height),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_sprite_addr (i_sprite_addr),
        .i_sprite_bits (i_sprite_bits),
        .i_read_row    (i_read_row),
        .i_read_half   (i_read_half),
        .o_st          (st),
        .o_done        (o_done),
        .o_read_pixels (o_read_pixels),
        .o_status      (o_status)
    );

endmodule

`default_nettype wire

// ----- design/msb_checker.sv -----
`default_nettype none

`include "mono_sprite_blitter_top_macros.svh"

module msb_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_done,
    input wire logic                          o_status,
    input wire logic [msb_pkg::READ_SPAN-1:0] o_read_pixels
);

    // A rejected command returns no pixels
    `MSB_ASSERT_IMPL(a_reject_zero, o_done && o_status, o_read_pixels == '0)

    // A result beat only shows once the block is free again
    `MSB_ASSERT_IMPL(a_done_idle, o_done, !busy)

    // Finishing a long command always delivers its beat
    `MSB_ASSERT_IMPL(a_fall_done, $fell(busy) && $past(i_rst_n), o_done)

    // A taken command either starts work or answers at once
    `MSB_ASSERT_NEXT(a_accept_next, start && !busy, busy || o_done)

endmodule

bind mono_sprite_blitter_top msb_checker u_msb_checker (.*);

`default_nettype wire
